[sv/dhd_pkg.sv]
// Shared types and constants for the detection head decoder.
// Depends on nothing; every other file in the block imports it.
`timescale 1ns / 1ps

package dhd_pkg;

    localparam int FRAC_W     = 16;
    localparam int CV_W       = 32;
    localparam int BOX_W      = 40;
    localparam int CLS_W      = 7;
    localparam int DIM_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Channel positions inside one candidate.
    localparam int CH_CENTER_X   = 0;
    localparam int CH_CENTER_Y   = 1;
    localparam int CH_WIDTH      = 2;
    localparam int CH_HEIGHT     = 3;
    localparam int CH_OBJECTNESS = 4;
    localparam int CH_BOX_COUNT  = 4;

    localparam logic signed [CV_W-1:0] CONF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CV_W-1:0] CONF_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WITH_OBJ       = 3'd0,
        CFG_CLASS_COUNT    = 3'd1,
        CFG_CONF_THRESHOLD = 3'd2,
        CFG_TILE_X         = 3'd3,
        CFG_TILE_Y         = 3'd4,
        CFG_SCALE_X        = 3'd5,
        CFG_SCALE_Y        = 3'd6,
        CFG_RASTER_SIZE    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                   with_obj;
        logic [7:0]             class_count;
        logic signed [CV_W-1:0] conf_threshold;
        logic [DIM_W-1:0]       tile_x;
        logic [DIM_W-1:0]       tile_y;
        logic [31:0]            scale_x;
        logic [31:0]            scale_y;
        logic [DIM_W-1:0]       raster_w;
        logic [DIM_W-1:0]       raster_h;
    } cfg_t;

    typedef struct packed {
        logic signed [CV_W-1:0] center_x;
        logic signed [CV_W-1:0] center_y;
        logic signed [CV_W-1:0] size_w;
        logic signed [CV_W-1:0] size_h;
        logic signed [CV_W-1:0] objectness;
        logic signed [CV_W-1:0] best_score;
        logic [CLS_W-1:0]       best_class;
    } cand_t;

    typedef struct packed {
        logic [BOX_W-1:0]       box_x;
        logic [BOX_W-1:0]       box_y;
        logic [BOX_W-1:0]       box_width;
        logic [BOX_W-1:0]       box_height;
        logic [CLS_W-1:0]       class_id;
        logic signed [CV_W-1:0] confidence;
    } det_t;

endpackage

[sv/dhd_if.sv]
// Valid/ready channel interfaces for the detection head decoder.
// Depends on dhd_pkg for the payload widths.
`timescale 1ns / 1ps

interface dhd_channel_if import dhd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [CV_W-1:0] channel_value;

    modport source (output valid, output channel_value, input ready);
    modport sink (input valid, input channel_value, output ready);
endinterface

interface dhd_detection_if import dhd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BOX_W-1:0]       box_x;
    logic [BOX_W-1:0]       box_y;
    logic [BOX_W-1:0]       box_width;
    logic [BOX_W-1:0]       box_height;
    logic [CLS_W-1:0]       class_id;
    logic signed [CV_W-1:0] confidence;

    modport source (output valid, output box_x, output box_y, output box_width,
                    output box_height, output class_id, output confidence,
                    input ready);
    modport sink (input valid, input box_x, input box_y, input box_width,
                  input box_height, input class_id, input confidence,
                  output ready);
endinterface

[sv/dhd_accum.sv]
// Channel accumulator: sorts each channel value into the candidate state,
// tracks the best class score and hands a finished candidate on. Uses dhd_pkg.
`timescale 1ns / 1ps

module dhd_accum import dhd_pkg::*; #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [CV_W-1:0] in_value,
    output logic                   cap_valid,
    input  logic                   cap_ready,
    output cand_t                  cap
);

    // The class count register is eight bits wide, so it caps the count too.
    localparam int CC_MAX = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int POS_W  = $clog2(CC_MAX + CH_BOX_COUNT + 2);
    localparam logic [7:0] CC_MAX_V = 8'(CC_MAX);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] cls_off;
    logic [POS_W:0]   pos_inc;
    logic [7:0]       cc_eff;
    logic             last;
    logic             accept;
    cand_t            cand_reg;
    cand_t            cand_next;
    logic             cap_valid_reg;
    cand_t            cap_reg;

    assign accept   = in_valid && in_ready;
    assign in_ready = !cap_valid_reg || cap_ready;

    always_comb
    begin
        if (cfg.class_count == 8'd0)
        begin
            cc_eff = 8'd1;
        end
        else if (cfg.class_count > CC_MAX_V)
        begin
            cc_eff = CC_MAX_V;
        end
        else
        begin
            cc_eff = cfg.class_count;
        end
        base    = POS_W'(CH_BOX_COUNT) + POS_W'(cfg.with_obj);
        total   = base + POS_W'(cc_eff);
        pos_inc = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};
        // A shrunken channel total after a configuration change also ends
        // the candidate here.
        last    = pos_inc >= {1'b0, total};
        cls_off = pos_reg - base;
    end

    always_comb
    begin
        cand_next = cand_reg;
        if (pos_reg == POS_W'(CH_CENTER_X))
        begin
            cand_next.center_x = in_value;
        end
        else if (pos_reg == POS_W'(CH_CENTER_Y))
        begin
            cand_next.center_y = in_value;
        end
        else if (pos_reg == POS_W'(CH_WIDTH))
        begin
            cand_next.size_w = in_value;
        end
        else if (pos_reg == POS_W'(CH_HEIGHT))
        begin
            cand_next.size_h = in_value;
        end
        else if (cfg.with_obj && pos_reg == POS_W'(CH_OBJECTNESS))
        begin
            cand_next.objectness = in_value;
        end
        else if (pos_reg == base || in_value > $signed(cand_reg.best_score))
        begin
            // Strict compare: the first class keeps a tie.
            cand_next.best_score = in_value;
            cand_next.best_class = CLS_W'(cls_off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cand_reg      <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg  <= last ? '0 : pos_inc[POS_W-1:0];
                cand_reg <= cand_next;
            end
            if (accept && last)
            begin
                cap_valid_reg <= 1'b1;
            end
            else if (cap_ready)
            begin
                cap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            cap_reg <= cand_next;
        end
    end

    assign cap_valid = cap_valid_reg;
    assign cap       = cap_reg;

`ifndef SYNTHESIS
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == '0 && cap_valid_reg))
        else $error("candidate did not restart after its last channel");
`endif

endmodule

[sv/dhd_box.sv]
// Box pipeline: confidence, gating, raster mapping, clamping and the result
// register for one finished candidate. Uses dhd_pkg.
`timescale 1ns / 1ps

module dhd_box import dhd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  cap_valid,
    output logic  cap_ready,
    input  cand_t cap,
    output logic  det_valid,
    input  logic  det_ready,
    output det_t  det
);

    localparam int DX_W = CV_W + 1;
    localparam int PX_W = 2 * CV_W + 1;
    localparam int PW_W = 2 * CV_W;
    localparam int XW   = 52;

    // Stage valid flags and per-stage ready.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_free;

    // Stage 1: half sizes and conf product.
    logic signed [PW_W-1:0] s1_conf_prod_reg;
    logic signed [CV_W-1:0] s1_best_reg;
    logic signed [DX_W-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [CV_W-1:0] s1_w_reg, s1_h_reg;
    logic [CLS_W-1:0]       s1_cls_reg;
    logic signed [CV_W-1:0] half_w, half_h;

    // Stage 2: scaling products and the gate.
    logic signed [PX_W-1:0] s2_px_reg, s2_py_reg;
    logic signed [PW_W-1:0] s2_pw_reg, s2_ph_reg;
    logic signed [CV_W-1:0] s2_conf_reg;
    logic                   s2_gate_reg;
    logic [CLS_W-1:0]       s2_cls_reg;
    logic signed [47:0]     conf_wide;
    logic signed [CV_W-1:0] conf_c;

    // Stage 3: raster edges before clamping.
    logic signed [XW-1:0]   s3_x_reg, s3_y_reg, s3_xe_reg, s3_ye_reg;
    logic signed [CV_W-1:0] s3_conf_reg;
    logic                   s3_gate_reg;
    logic [CLS_W-1:0]       s3_cls_reg;
    logic signed [XW-1:0]   x_c, y_c;

    // Output stage.
    logic [BOX_W-1:0]       x1, y1, x2, y2, hi_x, hi_y;
    logic                   keep;
    det_t                   det_reg;

    function automatic logic [BOX_W-1:0] clamp_edge(
        input logic signed [XW-1:0] v,
        input logic [BOX_W-1:0]     hi
    );
        logic [BOX_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({{(XW - BOX_W){1'b0}}, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[BOX_W-1:0];
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || det_ready;
    assign s3_ready  = !s3_valid_reg || out_free;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign cap_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= cap_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            // A candidate that fails the gate or has an empty box leaves
            // the pipeline here without a transaction.
            if (s3_valid_reg && out_free)
            begin
                out_valid_reg <= keep;
            end
            else if (det_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Halving rounds toward minus infinity, as an arithmetic shift does.
    assign half_w = $signed(cap.size_w) >>> 1;
    assign half_h = $signed(cap.size_h) >>> 1;

    always_ff @(posedge clk)
    begin
        if (s1_ready && cap_valid)
        begin
            s1_conf_prod_reg <= PW_W'($signed(cap.objectness)) *
                                PW_W'($signed(cap.best_score));
            s1_best_reg      <= cap.best_score;
            s1_dx_reg        <= DX_W'($signed(cap.center_x)) - DX_W'(half_w);
            s1_dy_reg        <= DX_W'($signed(cap.center_y)) - DX_W'(half_h);
            s1_w_reg         <= cap.size_w;
            s1_h_reg         <= cap.size_h;
            s1_cls_reg       <= cap.best_class;
        end
    end

    always_comb
    begin
        conf_wide = $signed(s1_conf_prod_reg[PW_W-1:FRAC_W]);
        if (!cfg.with_obj)
        begin
            conf_c = s1_best_reg;
        end
        else if (!conf_wide[47] && (|conf_wide[46:31]))
        begin
            conf_c = CONF_MAX;
        end
        else if (conf_wide[47] && !(&conf_wide[46:31]))
        begin
            conf_c = CONF_MIN;
        end
        else
        begin
            conf_c = conf_wide[CV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_px_reg   <= PX_W'(s1_dx_reg) * PX_W'($signed({1'b0, cfg.scale_x}));
            s2_py_reg   <= PX_W'(s1_dy_reg) * PX_W'($signed({1'b0, cfg.scale_y}));
            s2_pw_reg   <= PW_W'(s1_w_reg) * PW_W'($signed({1'b0, cfg.scale_x}));
            s2_ph_reg   <= PW_W'(s1_h_reg) * PW_W'($signed({1'b0, cfg.scale_y}));
            s2_conf_reg <= conf_c;
            s2_gate_reg <= conf_c >= cfg.conf_threshold;
            s2_cls_reg  <= s1_cls_reg;
        end
    end

    always_comb
    begin
        x_c = XW'($signed({1'b0, cfg.tile_x, {FRAC_W{1'b0}}})) +
              XW'($signed(s2_px_reg[PX_W-1:FRAC_W]));
        y_c = XW'($signed({1'b0, cfg.tile_y, {FRAC_W{1'b0}}})) +
              XW'($signed(s2_py_reg[PX_W-1:FRAC_W]));
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_x_reg    <= x_c;
            s3_y_reg    <= y_c;
            s3_xe_reg   <= x_c + XW'($signed(s2_pw_reg[PW_W-1:FRAC_W]));
            s3_ye_reg   <= y_c + XW'($signed(s2_ph_reg[PW_W-1:FRAC_W]));
            s3_conf_reg <= s2_conf_reg;
            s3_gate_reg <= s2_gate_reg;
            s3_cls_reg  <= s2_cls_reg;
        end
    end

    always_comb
    begin
        hi_x = {cfg.raster_w, {FRAC_W{1'b0}}};
        hi_y = {cfg.raster_h, {FRAC_W{1'b0}}};
        x1   = clamp_edge(s3_x_reg, hi_x);
        y1   = clamp_edge(s3_y_reg, hi_y);
        x2   = clamp_edge(s3_xe_reg, hi_x);
        y2   = clamp_edge(s3_ye_reg, hi_y);
        keep = s3_gate_reg && (x2 > x1) && (y2 > y1);
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_free && keep)
        begin
            det_reg.box_x      <= x1;
            det_reg.box_y      <= y1;
            det_reg.box_width  <= x2 - x1;
            det_reg.box_height <= y2 - y1;
            det_reg.class_id   <= s3_cls_reg;
            det_reg.confidence <= s3_conf_reg;
        end
    end

    assign det_valid = out_valid_reg;
    assign det       = det_reg;

`ifndef SYNTHESIS
    a_box_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (det_reg.box_width != '0 && det_reg.box_height != '0))
        else $error("empty box presented as a result");

    a_edge_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !out_free) |=> s3_valid_reg)
        else $error("candidate lost while the result register was blocked");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("candidate dropped between the first two stages");
`endif

endmodule

[sv/detection_head_decode_core.sv]
// Detection head decoder top level: configuration registers, accumulator, box pipeline.
// Accepts one channel value per cycle while the capture register is free or being taken;
// a candidate is 4 + objectness + class count channels. After its last channel is accepted,
// the capture register loads, then the four box stages follow; at most one result per candidate.
// rst_n clears the channel position, candidate state, stage flags and configuration to defaults.
`timescale 1ns / 1ps

module detection_head_decode_core import dhd_pkg::*; #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dhd_channel_if.sink           channel,
    dhd_detection_if.source       detection
);

    cfg_t  cfg_reg;
    logic  cap_valid;
    logic  cap_ready;
    cand_t cap;
    det_t  det;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.with_obj       <= 1'b0;
            cfg_reg.class_count    <= 8'd1;
            cfg_reg.conf_threshold <= '0;
            cfg_reg.tile_x         <= '0;
            cfg_reg.tile_y         <= '0;
            cfg_reg.scale_x        <= 32'h0001_0000;
            cfg_reg.scale_y        <= 32'h0001_0000;
            cfg_reg.raster_w       <= '0;
            cfg_reg.raster_h       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WITH_OBJ:       cfg_reg.with_obj       <= cfg_data[0];
                CFG_CLASS_COUNT:    cfg_reg.class_count    <= cfg_data[7:0];
                CFG_CONF_THRESHOLD: cfg_reg.conf_threshold <= $signed(cfg_data[31:0]);
                CFG_TILE_X:         cfg_reg.tile_x         <= cfg_data[DIM_W-1:0];
                CFG_TILE_Y:         cfg_reg.tile_y         <= cfg_data[DIM_W-1:0];
                CFG_SCALE_X:        cfg_reg.scale_x        <= cfg_data[31:0];
                CFG_SCALE_Y:        cfg_reg.scale_y        <= cfg_data[31:0];
                CFG_RASTER_SIZE:
                begin
                    cfg_reg.raster_w <= cfg_data[2*DIM_W-1:DIM_W];
                    cfg_reg.raster_h <= cfg_data[DIM_W-1:0];
                end
                default: ;
            endcase
        end
    end

    dhd_accum #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (channel.valid),
        .in_ready  (channel.ready),
        .in_value  (channel.channel_value),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap       (cap)
    );

    dhd_box u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap       (cap),
        .det_valid (detection.valid),
        .det_ready (detection.ready),
        .det       (det)
    );

    assign detection.box_x      = det.box_x;
    assign detection.box_y      = det.box_y;
    assign detection.box_width  = det.box_width;
    assign detection.box_height = det.box_height;
    assign detection.class_id   = det.class_id;
    assign detection.confidence = det.confidence;

endmodule
